// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: label");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: label");
`endif

// ===== rtl/clm_pkg.sv =====
// ----------------------------------------------------------------------------
// clm_pkg
// Shared types and constants of the cubic-linear template morphing block.
// ----------------------------------------------------------------------------
package clm_pkg;
  localparam int NUM_BINS = 64;
  localparam int NUM_SYSTEMATICS = 8;
  localparam int BIN_W = 6;
  localparam int SYS_W = 3;
  localparam int ADDR_W = BIN_W + SYS_W;
  localparam int DATA_W = 32;
  localparam int ONE_Q16 = 65536;

  typedef enum logic [2:0] {
    KIND_NOMINAL = 3'd0,
    KIND_PLUS    = 3'd1,
    KIND_MINUS   = 3'd2,
    KIND_PARAM   = 3'd3,
    KIND_FACTOR  = 3'd4,
    KIND_EVAL    = 3'd5
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DELTA, ST_DSAT, ST_NOM, ST_RD, ST_TERMS, ST_D3, ST_MUL,
    ST_ACC, ST_OUT
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic             nom_we;
    logic             plus_we;
    logic             minus_we;
    logic             par_we;
    logic             fac_we;
    logic             delta_mul;
    logic             delta_sat;
    logic             acc_init;
    logic             rd;
    logic             terms;
    logic             d3;
    logic             mul;
    logic             acc_add;
    logic             out_load;
    logic [SYS_W-1:0] sys;
    logic [BIN_W-1:0] bin;
  } cmd_t;
endpackage

// ===== rtl/clm_ram.sv =====
// ----------------------------------------------------------------------------
// clm_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module clm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end
endmodule

// ===== rtl/clm_datapath.sv =====
// ----------------------------------------------------------------------------
// clm_datapath
// Stores, delta multiplier, contribution arithmetic and bin accumulator.
// ----------------------------------------------------------------------------
module clm_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  clm_pkg::cmd_t         cmd,
  input  logic [31:0]           wdata,
  output logic [30:0]           out_value
);
  logic [clm_pkg::ADDR_W-1:0] taddr;
  logic [31:0] nom_q, plus_q, minus_q;
  logic signed [31:0] par_r [clm_pkg::NUM_SYSTEMATICS];
  logic signed [31:0] fac_r [clm_pkg::NUM_SYSTEMATICS];
  logic signed [63:0] prod_r;
  logic signed [31:0] delta_r;
  logic [31:0] ad_r;
  logic lin_r;
  logic signed [31:0] p_r, m_r;
  logic signed [32:0] diff_r, sum_r;
  logic signed [33:0] d2_r;
  logic signed [33:0] d3_r;
  logic signed [65:0] t1_r, t2_r;
  logic signed [65:0] lin_prod_r;
  logic signed [63:0] acc_r;
  logic signed [33:0] d2_nxt;
  logic signed [67:0] cub_sum;

  assign taddr = {cmd.sys, cmd.bin};

  clm_ram #(.WIDTH(32), .DEPTH(clm_pkg::NUM_BINS)) u_nom (
    .clk(clk), .we(cmd.nom_we), .addr(cmd.bin), .wdata(wdata), .rdata(nom_q));
  clm_ram #(.WIDTH(32), .DEPTH(clm_pkg::NUM_BINS * clm_pkg::NUM_SYSTEMATICS)) u_plus (
    .clk(clk), .we(cmd.plus_we), .addr(taddr), .wdata(wdata), .rdata(plus_q));
  clm_ram #(.WIDTH(32), .DEPTH(clm_pkg::NUM_BINS * clm_pkg::NUM_SYSTEMATICS)) u_minus (
    .clk(clk), .we(cmd.minus_we), .addr(taddr), .wdata(wdata), .rdata(minus_q));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < clm_pkg::NUM_SYSTEMATICS; i++) begin
        par_r[i] <= '0;
        fac_r[i] <= 32'(clm_pkg::ONE_Q16);
      end
    end else begin
      if (cmd.par_we) par_r[cmd.sys] <= wdata;
      if (cmd.fac_we) fac_r[cmd.sys] <= wdata;
    end
  end

  assign d2_nxt = 34'((66'(delta_r) * 66'(delta_r)) >>> 16);
  // Bracket of the cubic branch before the final divide by 2^17.
  assign cub_sum = 68'(t1_r) + 68'(t2_r);

  always_ff @(posedge clk) begin
    if (cmd.delta_mul) begin
      prod_r <= 64'(par_r[cmd.sys]) * 64'(fac_r[cmd.sys]);
    end
    if (cmd.delta_sat) begin
      // Arithmetic shift is a floor divide; then saturate to 32 bits.
      if ((prod_r >>> 16) > 64'sh7FFFFFFF) delta_r <= 32'sh7FFFFFFF;
      else if ((prod_r >>> 16) < -64'sh80000000) delta_r <= 32'sh80000000;
      else delta_r <= 32'(prod_r >>> 16);
    end
    if (cmd.terms) begin
      p_r    <= plus_q;
      m_r    <= minus_q;
      diff_r <= 33'(signed'(plus_q)) - 33'(signed'(minus_q));
      sum_r  <= 33'(signed'(plus_q)) + 33'(signed'(minus_q));
      ad_r   <= delta_r[31] ? 32'(-33'(delta_r)) : delta_r;
      lin_r  <= (delta_r >= 32'sd65536) || (delta_r <= -32'sd65536);
      d2_r   <= d2_nxt;
    end
    if (cmd.d3) begin
      d3_r <= 34'((68'(d2_r) * 68'(signed'({1'b0, ad_r}))) >>> 16);
      lin_prod_r <= 66'(signed'({1'b0, ad_r})) *
                    66'(delta_r[31] ? m_r : p_r);
    end
    if (cmd.mul) begin
      t1_r <= 66'(delta_r) * 66'(diff_r);
      t2_r <= 66'(68'(2) * 68'(d2_r) - 68'(d3_r)) * 66'(sum_r);
    end
    if (cmd.acc_init) begin
      acc_r <= 64'(signed'(nom_q));
    end else if (cmd.acc_add) begin
      if (lin_r) acc_r <= acc_r + 64'(lin_prod_r >>> 16);
      else       acc_r <= acc_r + 64'(cub_sum >>> 17);
    end
    if (cmd.out_load) begin
      if (acc_r < 0) out_value <= '0;
      else if (acc_r > 64'sh7FFFFFFF) out_value <= 31'h7FFFFFFF;
      else out_value <= acc_r[30:0];
    end
  end
endmodule

// ===== rtl/clm_ctrl.sv =====
// ----------------------------------------------------------------------------
// clm_ctrl
// Sequencer: decodes loads, walks bins and systematics on evaluate.
// ----------------------------------------------------------------------------
module clm_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [2:0]                   in_kind,
  input  logic [clm_pkg::SYS_W-1:0]    in_sys,
  input  logic [clm_pkg::BIN_W-1:0]    in_bin,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [clm_pkg::BIN_W-1:0]    out_bin,
  output logic                         out_last,
  output clm_pkg::cmd_t                cmd
);
  clm_pkg::state_t state_r, state_nxt;
  logic [clm_pkg::SYS_W-1:0] sys_r, sys_nxt;
  logic [clm_pkg::BIN_W-1:0] bin_r, bin_nxt;
  logic valid_r, valid_nxt;
  logic [clm_pkg::BIN_W-1:0] obin_r, obin_nxt;
  logic acc;

  assign out_tvalid = valid_r;
  assign out_bin    = obin_r;
  assign out_last   = (obin_r == clm_pkg::BIN_W'(clm_pkg::NUM_BINS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= clm_pkg::ST_IDLE;
      valid_r <= 1'b0;
      sys_r <= '0;
      bin_r <= '0;
      obin_r <= '0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      sys_r <= sys_nxt;
      bin_r <= bin_nxt;
      obin_r <= obin_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    sys_nxt = sys_r;
    bin_nxt = bin_r;
    obin_nxt = obin_r;
    valid_nxt = valid_r && !out_tready;
    cmd = '0;
    cmd.sys = sys_r;
    cmd.bin = bin_r;
    in_tready = 1'b0;
    acc = 1'b0;
    case (state_r)
      clm_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        acc = in_tvalid;
        cmd.sys = in_sys;
        cmd.bin = in_bin;
        if (acc) begin
          case (in_kind)
            clm_pkg::KIND_NOMINAL: cmd.nom_we = 1'b1;
            clm_pkg::KIND_PLUS:    cmd.plus_we = 1'b1;
            clm_pkg::KIND_MINUS:   cmd.minus_we = 1'b1;
            clm_pkg::KIND_PARAM:   cmd.par_we = 1'b1;
            clm_pkg::KIND_FACTOR:  cmd.fac_we = 1'b1;
            clm_pkg::KIND_EVAL: begin
              bin_nxt = '0;
              sys_nxt = '0;
              state_nxt = clm_pkg::ST_NOM;
            end
            default: ;
          endcase
        end
      end
      clm_pkg::ST_NOM: begin
        // Nominal read address is presented; next cycle loads the accumulator.
        state_nxt = clm_pkg::ST_DELTA;
      end
      clm_pkg::ST_DELTA: begin
        if (sys_r == '0) cmd.acc_init = 1'b1;
        cmd.delta_mul = 1'b1;
        state_nxt = clm_pkg::ST_DSAT;
      end
      clm_pkg::ST_DSAT: begin
        cmd.delta_sat = 1'b1;
        state_nxt = clm_pkg::ST_RD;
      end
      clm_pkg::ST_RD: begin
        cmd.terms = 1'b1;
        state_nxt = clm_pkg::ST_D3;
      end
      clm_pkg::ST_D3: begin
        cmd.d3 = 1'b1;
        state_nxt = clm_pkg::ST_MUL;
      end
      clm_pkg::ST_MUL: begin
        cmd.mul = 1'b1;
        state_nxt = clm_pkg::ST_ACC;
      end
      clm_pkg::ST_ACC: begin
        cmd.acc_add = 1'b1;
        if (sys_r == clm_pkg::SYS_W'(clm_pkg::NUM_SYSTEMATICS - 1)) begin
          state_nxt = clm_pkg::ST_OUT;
        end else begin
          sys_nxt = sys_r + 1'b1;
          state_nxt = clm_pkg::ST_DELTA;
        end
      end
      clm_pkg::ST_OUT: begin
        if (!valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          valid_nxt = 1'b1;
          obin_nxt = bin_r;
          sys_nxt = '0;
          if (bin_r == clm_pkg::BIN_W'(clm_pkg::NUM_BINS - 1)) begin
            state_nxt = clm_pkg::ST_IDLE;
          end else begin
            bin_nxt = bin_r + 1'b1;
            state_nxt = clm_pkg::ST_NOM;
          end
        end
      end
      default: state_nxt = clm_pkg::ST_IDLE;
    endcase
  end
endmodule

// ===== rtl/cubic_linear_template_morph.sv =====
// ----------------------------------------------------------------------------
// cubic_linear_template_morph
// Cubic-linear histogram template morphing engine, Q16.16.
// ----------------------------------------------------------------------------
// Channel  Dir  Contents
// in_      in   load or evaluate transaction, kind on tuser
// out_     out  one morphed bin per transaction, last on the final bin
//
// A load is written when it is accepted. An evaluate takes each bin through
// the nominal read, then the delta, saturate, read, d3, multiply and
// accumulate steps for one systematic at a time on the shared delta and term
// multipliers, then the output load. The last bin's result is held in an
// output register while the next transaction is taken. Reset is synchronous;
// a stalled output holds the sequencer before the next bin.
module cubic_linear_template_morph (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [2:0]  in_tuser,   // kind[2:0]
  input  logic [47:0] in_tdata,   // sys_index[2:0], bin_index[8:3], value[40:9]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // bin_number[5:0], bin_value[36:6]
  output logic        out_tlast
);
  clm_pkg::cmd_t cmd;
  logic [30:0] value_q;
  logic [clm_pkg::BIN_W-1:0] obin;

  clm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_kind(in_tuser), .in_sys(in_tdata[2:0]), .in_bin(in_tdata[8:3]),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_bin(obin),
    .out_last(out_tlast), .cmd(cmd));

  clm_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .wdata(in_tdata[40:9]),
    .out_value(value_q));

  assign out_tdata = {3'b000, value_q, obin};
endmodule

// ===== rtl/clm_checker.sv =====
// ----------------------------------------------------------------------------
// clm_checker
// Port-level checks of the morphing engine.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module clm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tlast
);
  `ASSERT_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `ASSERT_IMPL(a_last, clk, rst_n, out_tvalid, out_tlast == (out_tdata[5:0] == 6'd63))
  `ASSERT_IMPL(a_pad, clk, rst_n, out_tvalid, out_tdata[39:37] == 3'b000)
  // Until the final bin is in the output register, the evaluation is running.
  `ASSERT_IMPL(a_busy, clk, rst_n, out_tvalid && !out_tlast, !in_tready)
endmodule

bind cubic_linear_template_morph clm_checker u_clm_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tlast(out_tlast));
